// ===== rtl/assert_macros.svh =====
// Shared assertion macros. Each expects clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CST_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cst_pkg.sv =====
package cst_pkg;

  // Deferred blank count ceiling
  localparam int unsigned BLANK_COUNT_MAX = 255;
  localparam logic [7:0] BLANK_LIMIT = 8'((BLANK_COUNT_MAX < 255) ? BLANK_COUNT_MAX : 255);

  // Characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // Input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE       = 2'd0,
    KIND_FIELD_END  = 2'd1,
    KIND_RECORD_END = 2'd2
  } kind_t;

  // Register map: index taken from paddr[2]
  localparam int unsigned ADDR_W   = 3;
  localparam logic       REG_DELIM  = 1'b0;
  localparam logic       REG_WSMODE = 1'b1;

  // Output queue
  localparam int unsigned RES_MAX    = 2;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  typedef struct packed {
    logic [7:0] delimiter_char;
    logic       whitespace_mode;
  } cfg_t;

  typedef struct packed {
    logic       in_quote;
    logic       quote_seen;
    logic       field_fresh;
    logic       line_start;
    logic       separator_pending;
    logic       field_nonblank_seen;
    logic [7:0] blank_run_count;
    logic       field_has_bytes;
    logic       row_has_fields;
  } state_t;

  localparam state_t STATE_RESET = '{
    in_quote:            1'b0,
    quote_seen:          1'b0,
    field_fresh:         1'b1,
    line_start:          1'b1,
    separator_pending:   1'b0,
    field_nonblank_seen: 1'b0,
    blank_run_count:     8'd0,
    field_has_bytes:     1'b0,
    row_has_fields:      1'b0
  };

  typedef struct packed {
    kind_t      kind;
    logic [7:0] content_byte;
    logic [7:0] blanks_before;
    logic       last_result;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

endpackage

// ===== rtl/csv_stream_tokenizer_core.sv =====
// CSV stream tokenizer (RFC 4180 quoting, optional trimming and blank-run separators).
// Input channel: one beat per text byte (in_op = 0) or end of text (in_op = 1), taken at
// a clock edge with in_valid high and in_stall low.
// Output channel: one beat per result: content byte with deferred blank count, field end
// or record end. out_last_result marks the final result of an input beat. A beat moves
// when out_valid is high and out_stall is low.
// Each input beat is decoded combinationally and its results are written to the output
// queue at acceptance. One input beat is accepted every cycle while at least two of the
// four output queue entries are free; a beat that yields two results presents them one
// after the other on the output port, so the output port sets the sustained rate.
// While out_stall is high, results collect in the queue and in_stall rises once fewer
// than two entries are free; held results stay stable on the port.
// Configuration via APB at byte address 0 (delimiter, reset comma) and 4 (whitespace
// mode, reset off); write only while no input is in flight.
// Synchronous reset (rst_n low) empties the queue, restores the parser to line start
// and restores the register defaults.
`include "assert_macros.svh"

module csv_stream_tokenizer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic [7:0]                 in_text_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_kind,
  output logic [7:0]                 out_content_byte,
  output logic [7:0]                 out_blanks_before,
  output logic                       out_last_result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cst_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  cst_pkg::cfg_t    cfg;
  cst_pkg::state_t  state_r, state_nxt;
  cst_pkg::result_t res [cst_pkg::RES_MAX];
  cst_pkg::result_t head;
  logic [1:0]       res_n;
  logic             accept;
  logic             full;

  cst_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cst_step u_step (
    .state_i   (state_r),
    .cfg       (cfg),
    .op        (in_op),
    .text_byte (in_text_byte),
    .state_o   (state_nxt),
    .res_n     (res_n),
    .res       (res)
  );

  assign in_stall = full;
  assign accept   = in_valid & ~in_stall;

  // Hold parser state until a beat is accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cst_pkg::STATE_RESET;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  cst_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_n    (res_n),
    .push_res  (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_kind          = head.kind;
  assign out_content_byte  = head.content_byte;
  assign out_blanks_before = head.blanks_before;
  assign out_last_result   = head.last_result;

  `CST_ASSERT(a_qs_in_quote, state_r.quote_seen, state_r.in_quote, "quote_seen outside quotes")
  `CST_ASSERT(a_sep_unquoted, state_r.separator_pending, !state_r.in_quote,
              "separator pending inside quotes")
  `CST_ASSERT(a_run_after_text, state_r.blank_run_count != 8'd0, state_r.field_nonblank_seen,
              "blank run counted before field text")

endmodule

// ===== rtl/cst_cfg.sv =====
module cst_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cst_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output cst_pkg::cfg_t              cfg
);

  logic [7:0] delim_r, delim_nxt;
  logic       wsmode_r, wsmode_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Decode register writes
  always_comb begin
    delim_nxt  = delim_r;
    wsmode_nxt = wsmode_r;
    if (wr_en) begin
      unique case (paddr[2])
        cst_pkg::REG_DELIM:  delim_nxt  = pwdata[7:0];
        cst_pkg::REG_WSMODE: wsmode_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r  <= cst_pkg::CH_COMMA;
      wsmode_r <= 1'b0;
    end else begin
      delim_r  <= delim_nxt;
      wsmode_r <= wsmode_nxt;
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[2])
      cst_pkg::REG_DELIM:  prdata = {24'd0, delim_r};
      cst_pkg::REG_WSMODE: prdata = {31'd0, wsmode_r};
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg.delimiter_char  = delim_r;
  assign cfg.whitespace_mode = wsmode_r;

endmodule

// ===== rtl/cst_step.sv =====
module cst_step (
  input  cst_pkg::state_t  state_i,
  input  cst_pkg::cfg_t    cfg,
  input  logic             op,
  input  logic [7:0]       text_byte,
  output cst_pkg::state_t  state_o,
  output logic [1:0]       res_n,
  output cst_pkg::result_t res [cst_pkg::RES_MAX]
);

  cst_pkg::state_t  st;
  cst_pkg::result_t r0, r1;
  logic [1:0]       n;
  logic [7:0]       eff_delim;
  logic             trim;
  logic             c_blank;
  logic             do_out;
  logic             do_cont;
  logic [7:0]       cch;

  assign eff_delim = (cfg.delimiter_char == 8'd0) ? cst_pkg::CH_COMMA : cfg.delimiter_char;
  assign trim      = cfg.whitespace_mode || (eff_delim != cst_pkg::CH_COMMA);
  assign c_blank   = cst_pkg::is_blank(text_byte);

  // Walk one byte through the quoting, separator and trimming rules
  always_comb begin
    st      = state_i;
    n       = 2'd0;
    r0      = '0;
    r1      = '0;
    do_out  = 1'b0;
    do_cont = 1'b0;
    cch     = text_byte;

    if (op == cst_pkg::OP_END) begin
      // Close any pending row and return to the start state
      if (st.field_has_bytes || st.row_has_fields) begin
        r0.kind = cst_pkg::KIND_RECORD_END;
        n       = 2'd1;
      end
      st = cst_pkg::STATE_RESET;
    end else if (st.in_quote) begin
      if (st.quote_seen) begin
        st.quote_seen = 1'b0;
        if (text_byte == cst_pkg::CH_QUOTE) begin
          do_cont = 1'b1;
        end else begin
          st.in_quote = 1'b0;
          do_out      = 1'b1;
        end
      end else if (text_byte == cst_pkg::CH_QUOTE) begin
        st.quote_seen = 1'b1;
      end else begin
        do_cont = 1'b1;
      end
    end else begin
      do_out = 1'b1;
      // Resolve a pending blank-run separator
      if (st.separator_pending) begin
        if (c_blank) begin
          do_out = 1'b0;
        end else begin
          st.separator_pending = 1'b0;
          if (text_byte != cst_pkg::CH_LF && text_byte != cst_pkg::CH_CR) begin
            r0.kind                = cst_pkg::KIND_FIELD_END;
            n                      = 2'd1;
            st.field_fresh         = 1'b1;
            st.field_nonblank_seen = 1'b0;
            st.blank_run_count     = 8'd0;
            st.field_has_bytes     = 1'b0;
            st.row_has_fields      = 1'b1;
          end
        end
      end
    end

    // Unquoted byte handling
    if (do_out) begin
      if (cfg.whitespace_mode && st.line_start && c_blank) begin
        // drop blanks at line start
      end else begin
        if (cfg.whitespace_mode) begin
          st.line_start = 1'b0;
        end
        if (text_byte == cst_pkg::CH_QUOTE && st.field_fresh) begin
          st.in_quote    = 1'b1;
          st.field_fresh = 1'b0;
          if (trim) begin
            st.field_has_bytes = 1'b0;
          end
        end else if (cfg.whitespace_mode && c_blank) begin
          st.separator_pending = 1'b1;
        end else if ((!cfg.whitespace_mode && text_byte == eff_delim) ||
                     text_byte == cst_pkg::CH_LF) begin
          if (n == 2'd0) begin
            r0.kind = (!cfg.whitespace_mode && text_byte == eff_delim) ?
                      cst_pkg::KIND_FIELD_END : cst_pkg::KIND_RECORD_END;
          end else begin
            r1.kind = (!cfg.whitespace_mode && text_byte == eff_delim) ?
                      cst_pkg::KIND_FIELD_END : cst_pkg::KIND_RECORD_END;
          end
          n                      = n + 2'd1;
          st.field_fresh         = 1'b1;
          st.field_nonblank_seen = 1'b0;
          st.blank_run_count     = 8'd0;
          st.field_has_bytes     = 1'b0;
          st.row_has_fields      = 1'b1;
          if (cfg.whitespace_mode || text_byte != eff_delim) begin
            st.row_has_fields = 1'b0;
            st.line_start     = 1'b1;
          end
        end else if (text_byte == cst_pkg::CH_CR) begin
          // drop CR outside quotes
        end else begin
          do_cont = 1'b1;
          if (!(trim && c_blank)) begin
            st.field_fresh = 1'b0;
          end
        end
      end
    end

    // Field content: defer blanks in trim mode, otherwise emit the byte
    if (do_cont) begin
      st.field_has_bytes = 1'b1;
      if (trim && cst_pkg::is_blank(cch)) begin
        if (st.field_nonblank_seen && st.blank_run_count < cst_pkg::BLANK_LIMIT) begin
          st.blank_run_count = st.blank_run_count + 8'd1;
        end
      end else begin
        if (n == 2'd0) begin
          r0.kind          = cst_pkg::KIND_BYTE;
          r0.content_byte  = cch;
          r0.blanks_before = trim ? st.blank_run_count : 8'd0;
        end else begin
          r1.kind          = cst_pkg::KIND_BYTE;
          r1.content_byte  = cch;
          r1.blanks_before = trim ? st.blank_run_count : 8'd0;
        end
        n                      = n + 2'd1;
        st.blank_run_count     = 8'd0;
        st.field_nonblank_seen = 1'b1;
      end
    end

    r0.last_result = (n == 2'd1);
    r1.last_result = 1'b1;
  end

  assign state_o = st;
  assign res_n   = n;
  assign res[0]  = r0;
  assign res[1]  = r1;

endmodule

// ===== rtl/cst_ofifo.sv =====
`include "assert_macros.svh"

module cst_ofifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [1:0]       push_n,
  input  cst_pkg::result_t push_res [cst_pkg::RES_MAX],
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output cst_pkg::result_t head
);

  cst_pkg::result_t                 mem_r [cst_pkg::FIFO_DEPTH];
  logic [cst_pkg::FIFO_AW-1:0]      wp_r, wp_nxt;
  logic [cst_pkg::FIFO_AW-1:0]      rp_r, rp_nxt;
  logic [cst_pkg::FIFO_CW-1:0]      cnt_r, cnt_nxt;
  logic                             pop;
  logic [cst_pkg::FIFO_AW-1:0]      wp_plus1;

  // Room for a whole item's results is required before accepting
  assign full      = cnt_r > cst_pkg::FIFO_CW'(cst_pkg::FIFO_DEPTH - cst_pkg::RES_MAX);
  assign out_valid = cnt_r != '0;
  assign pop       = out_valid & ~out_stall;
  assign head      = mem_r[rp_r];
  assign wp_plus1  = wp_r + cst_pkg::FIFO_AW'(1);

  // Advance pointers and fill count
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt  = wp_r + cst_pkg::FIFO_AW'(push_n);
      cnt_nxt = cnt_nxt + cst_pkg::FIFO_CW'(push_n);
    end
    if (pop) begin
      rp_nxt  = rp_r + cst_pkg::FIFO_AW'(1);
      cnt_nxt = cnt_nxt - cst_pkg::FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store up to two result beats
  always_ff @(posedge clk) begin
    if (push && push_n != 2'd0) begin
      mem_r[wp_r] <= push_res[0];
    end
    if (push && push_n == 2'd2) begin
      mem_r[wp_plus1] <= push_res[1];
    end
  end

  `CST_ASSERT(a_cnt_bound, 1'b1, cnt_r <= cst_pkg::FIFO_CW'(cst_pkg::FIFO_DEPTH), "queue overfilled")
  `CST_ASSERT_NXT(a_push_shows, push && push_n != 2'd0, out_valid, "pushed beat not presented")
  `CST_ASSERT_NXT(a_pair_keeps, push && push_n == 2'd2 && !pop, cnt_r >= 3'd2, "second beat lost")

endmodule

// ===== dv/tb_csv_stream_tokenizer_core.sv =====
module tb_csv_stream_tokenizer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PHASE_BEATS   = 130;
  localparam int unsigned LONG_RUN      = 270;

  // Expected token stream of the tokenizer, built beat by beat
  class token_scoreboard;
    logic [7:0]       delim_reg;
    logic             ws_mode;
    bit               in_quote, quote_seen, field_fresh, line_start, sep_pending;
    bit               nonblank_seen, has_bytes, row_has_fields;
    logic [7:0]       blank_run;
    cst_pkg::result_t beat_tokens[$];
    cst_pkg::result_t expected_tokens[$];
    int               mismatches;

    function new();
      delim_reg  = cst_pkg::CH_COMMA;
      ws_mode    = 1'b0;
      mismatches = 0;
      in_quote   = 1'b0;
      quote_seen = 1'b0;
      line_start = 1'b1;
      sep_pending = 1'b0;
      row_has_fields = 1'b0;
      clear_field();
    endfunction

    function void set_register(logic idx, logic [7:0] value);
      if (idx == cst_pkg::REG_DELIM)
        delim_reg = value;
      else
        ws_mode = value[0];
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    function void flag(string msg);
      if (mismatches < 10)
        $display("%s", msg);
      mismatches++;
    endfunction

    function bit blank(logic [7:0] c);
      return c == cst_pkg::CH_SPACE || c == cst_pkg::CH_TAB;
    endfunction

    // Zero delimiter falls back to comma
    function logic [7:0] delim_eff();
      return (delim_reg == 8'd0) ? cst_pkg::CH_COMMA : delim_reg;
    endfunction

    function bit trimming();
      return ws_mode || delim_eff() != cst_pkg::CH_COMMA;
    endfunction

    function void push(cst_pkg::kind_t k, logic [7:0] c, logic [7:0] n);
      cst_pkg::result_t r;
      if (beat_tokens.size() >= cst_pkg::RES_MAX)
        return;
      r.kind          = k;
      r.content_byte  = c;
      r.blanks_before = n;
      r.last_result   = 1'b0;
      beat_tokens.push_back(r);
    endfunction

    function void clear_field();
      field_fresh   = 1'b1;
      nonblank_seen = 1'b0;
      blank_run     = 8'd0;
      has_bytes     = 1'b0;
    endfunction

    function void close_field(cst_pkg::kind_t k);
      push(k, 8'd0, 8'd0);
      clear_field();
      row_has_fields = 1'b1;
    endfunction

    // Defer blanks in trim mode, emit everything else with the deferred count
    function void take_content(logic [7:0] c);
      has_bytes = 1'b1;
      if (trimming() && blank(c)) begin
        if (nonblank_seen && blank_run < cst_pkg::BLANK_LIMIT)
          blank_run++;
        return;
      end
      push(cst_pkg::KIND_BYTE, c, trimming() ? blank_run : 8'd0);
      blank_run     = 8'd0;
      nonblank_seen = 1'b1;
    endfunction

    function void outside(logic [7:0] c);
      if (ws_mode && line_start) begin
        if (blank(c))
          return;
        line_start = 1'b0;
      end
      if (c == cst_pkg::CH_QUOTE && field_fresh) begin
        in_quote    = 1'b1;
        field_fresh = 1'b0;
        if (trimming())
          has_bytes = 1'b0;
        return;
      end
      if (ws_mode && blank(c)) begin
        sep_pending = 1'b1;
        return;
      end
      if (!ws_mode && c == delim_eff()) begin
        close_field(cst_pkg::KIND_FIELD_END);
        return;
      end
      if (c == cst_pkg::CH_LF) begin
        close_field(cst_pkg::KIND_RECORD_END);
        row_has_fields = 1'b0;
        line_start     = 1'b1;
        return;
      end
      if (c == cst_pkg::CH_CR)
        return;
      take_content(c);
      if (!(trimming() && blank(c)))
        field_fresh = 1'b0;
    endfunction

    // Advance the parser by one accepted beat and queue its tokens
    function void note_beat(logic op, logic [7:0] c);
      bit skip;
      skip = 1'b0;
      beat_tokens.delete();
      if (op == cst_pkg::OP_END) begin
        if (has_bytes || row_has_fields)
          push(cst_pkg::KIND_RECORD_END, 8'd0, 8'd0);
        in_quote       = 1'b0;
        quote_seen     = 1'b0;
        line_start     = 1'b1;
        sep_pending    = 1'b0;
        row_has_fields = 1'b0;
        clear_field();
      end else if (in_quote) begin
        if (quote_seen) begin
          quote_seen = 1'b0;
          if (c == cst_pkg::CH_QUOTE) begin
            take_content(cst_pkg::CH_QUOTE);
          end else begin
            in_quote = 1'b0;
            outside(c);
          end
        end else if (c == cst_pkg::CH_QUOTE) begin
          quote_seen = 1'b1;
        end else begin
          take_content(c);
        end
      end else begin
        if (sep_pending) begin
          if (blank(c)) begin
            skip = 1'b1;
          end else begin
            sep_pending = 1'b0;
            if (c != cst_pkg::CH_LF && c != cst_pkg::CH_CR)
              close_field(cst_pkg::KIND_FIELD_END);
          end
        end
        if (!skip)
          outside(c);
      end
      if (beat_tokens.size() > 0)
        beat_tokens[beat_tokens.size() - 1].last_result = 1'b1;
      foreach (beat_tokens[i])
        expected_tokens.push_back(beat_tokens[i]);
    endfunction

    function void check_token(logic [1:0] kind, logic [7:0] cbyte, logic [7:0] blanks,
                              logic last);
      cst_pkg::result_t want;
      if (expected_tokens.size() == 0) begin
        flag($sformatf("unexpected token: kind %0d byte %02h blanks %0d last %0d",
                       kind, cbyte, blanks, last));
        return;
      end
      want = expected_tokens.pop_front();
      if (want.kind !== kind || want.content_byte !== cbyte ||
          want.blanks_before !== blanks || want.last_result !== last)
        flag($sformatf({"token differs: expected kind %0d byte %02h blanks %0d last %0d,",
                        " got kind %0d byte %02h blanks %0d last %0d"},
                       want.kind, want.content_byte, want.blanks_before, want.last_result,
                       kind, cbyte, blanks, last));
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_op = cst_pkg::OP_BYTE;
  logic [7:0]                 in_text_byte = 8'd0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [1:0]                 out_kind;
  logic [7:0]                 out_content_byte;
  logic [7:0]                 out_blanks_before;
  logic                       out_last_result;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [cst_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                pwdata = 32'd0;
  logic [31:0]                prdata;
  logic                       pready;

  token_scoreboard board;
  int unsigned     beat_count = 0;
  bit              steady = 1'b0;

  csv_stream_tokenizer_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_text_byte      (in_text_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_content_byte  (out_content_byte),
    .out_blanks_before (out_blanks_before),
    .out_last_result   (out_last_result),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check results before noting the beat taken at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        board.check_token(out_kind, out_content_byte, out_blanks_before, out_last_result);
      if (in_valid && !in_stall)
        board.note_beat(in_op, in_text_byte);
    end
  end

  // Stall the result side at random, except during the steady stretch
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 30);
  end

  // Hold a beat until taken; called at a falling edge, returns at one
  task automatic send_beat(input logic op, input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_text_byte <= b;
    do @(posedge clk); while (in_stall);
    beat_count++;
    @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register and read it back
  task automatic write_reg(input logic idx, input logic [7:0] value);
    logic [31:0] readback;
    logic [31:0] want;
    want = (idx == cst_pkg::REG_DELIM) ? {24'd0, value} : {31'd0, value[0]};
    apb_access(1'b1, idx, want, readback);
    board.set_register(idx, value);
    @(negedge clk);
    apb_access(1'b0, idx, 32'd0, readback);
    if (readback !== want)
      board.flag($sformatf("register %0d read back %08h, expected %08h", idx, readback, want));
    @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] delim, input logic ws);
    write_reg(cst_pkg::REG_DELIM, delim);
    write_reg(cst_pkg::REG_WSMODE, {7'd0, ws});
  endtask

  // Drop valid and wait until every expected token has come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] blank_char();
    return $urandom_range(0, 1) ? cst_pkg::CH_SPACE : cst_pkg::CH_TAB;
  endfunction

  function automatic logic [7:0] sep_char();
    return (board.delim_reg == 8'd0) ? cst_pkg::CH_COMMA : board.delim_reg;
  endfunction

  function automatic logic [7:0] plain_char();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)
      return 8'(8'h61 + $urandom_range(0, 25));
    if (pick < 70)
      return 8'(8'h30 + $urandom_range(0, 9));
    if (pick < 85)
      return blank_char();
    return 8'($urandom_range(0, 255));
  endfunction

  // One field: optional edge blanks around plain or quoted content
  task automatic send_field();
    int unsigned lead;
    int unsigned len;
    int unsigned pick;
    lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (lead) send_beat(cst_pkg::OP_BYTE, blank_char());
    if ($urandom_range(0, 99) < 30) begin
      send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_QUOTE);
      len = $urandom_range(0, 5);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_QUOTE);
          send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_QUOTE);
        end else if (pick < 22) begin
          send_beat(cst_pkg::OP_BYTE, sep_char());
        end else if (pick < 27) begin
          send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_LF);
        end else if (pick < 30) begin
          send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_CR);
        end else begin
          send_beat(cst_pkg::OP_BYTE, plain_char());
        end
      end
      send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_QUOTE);
    end else begin
      len = $urandom_range(0, 6);
      repeat (len) send_beat(cst_pkg::OP_BYTE, plain_char());
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_beat(cst_pkg::OP_BYTE, blank_char());
  endtask

  task automatic send_record();
    int unsigned fields;
    int unsigned pick;
    fields = $urandom_range(1, 4);
    for (int unsigned f = 0; f < fields; f++) begin
      send_field();
      if (f + 1 < fields) begin
        if (board.ws_mode)
          repeat ($urandom_range(1, 3)) send_beat(cst_pkg::OP_BYTE, blank_char());
        else
          send_beat(cst_pkg::OP_BYTE, sep_char());
      end
    end
    pick = $urandom_range(0, 9);
    if (pick < 2)
      send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_CR);
    if (pick < 9)
      send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_LF);
    else
      send_beat(cst_pkg::OP_END, 8'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed records, some stray bytes and early ends, then close the text
  task automatic send_records(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = beat_count + budget;
    while (beat_count < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 85)
        send_record();
      else if (pick < 97)
        send_beat(cst_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
      else
        send_beat(cst_pkg::OP_END, 8'($urandom_range(0, 255)));
    end
    send_beat(cst_pkg::OP_END, 8'($urandom_range(0, 255)));
    wait_drain();
  endtask

  initial begin
    board = new();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Plain comma mode: empty quoted text, doubled quote, byte extremes, CR drop
    configure(cst_pkg::CH_COMMA, 1'b0);
    send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_QUOTE);
    send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_QUOTE);
    send_beat(cst_pkg::OP_END, 8'h00);
    send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_QUOTE);
    send_beat(cst_pkg::OP_BYTE, 8'h61);
    send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_QUOTE);
    send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_QUOTE);
    send_beat(cst_pkg::OP_BYTE, 8'h62);
    send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_QUOTE);
    send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_COMMA);
    send_beat(cst_pkg::OP_BYTE, 8'h00);
    send_beat(cst_pkg::OP_BYTE, 8'hFF);
    send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_CR);
    send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_LF);
    send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_SPACE);
    send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_TAB);
    send_beat(cst_pkg::OP_END, 8'hFF);
    send_beat(cst_pkg::OP_END, 8'h00);
    send_records(PHASE_BEATS);

    // Zero delimiter behaves as comma
    configure(8'h00, 1'b0);
    send_records(PHASE_BEATS);

    // Trim mode: blanks before an opening quote, then an overlong blank run
    configure(8'h3B, 1'b0);
    send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_SPACE);
    send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_QUOTE);
    send_beat(cst_pkg::OP_BYTE, 8'h61);
    send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_SPACE);
    send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_QUOTE);
    send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_SPACE);
    send_beat(cst_pkg::OP_END, 8'h5A);
    send_beat(cst_pkg::OP_BYTE, 8'h78);
    repeat (LONG_RUN) send_beat(cst_pkg::OP_BYTE, blank_char());
    send_beat(cst_pkg::OP_BYTE, 8'h79);
    send_beat(cst_pkg::OP_BYTE, cst_pkg::CH_LF);
    send_records(PHASE_BEATS);

    configure(cst_pkg::CH_TAB, 1'b0);
    send_records(PHASE_BEATS);

    // Run flat out on both sides for a while
    steady = 1'b1;
    configure(8'hFF, 1'b0);
    send_records(PHASE_BEATS);
    steady = 1'b0;

    configure(cst_pkg::CH_COMMA, 1'b1);
    send_records(PHASE_BEATS);

    configure(8'hFF, 1'b1);
    send_records(PHASE_BEATS);

    // Delimiter clashing with quote, LF and CR
    configure(cst_pkg::CH_QUOTE, 1'b0);
    send_records(PHASE_BEATS);

    configure(cst_pkg::CH_LF, 1'b0);
    send_records(PHASE_BEATS);

    configure(cst_pkg::CH_CR, 1'b0);
    send_records(PHASE_BEATS);

    if (board.mismatches == 0 && board.pending() == 0)
      $display("csv_stream_tokenizer_core: match");
    else
      $display("csv_stream_tokenizer_core: mismatch");
    $finish;
  end

  // Give up on a hung run
  initial begin
    #(5_000_000);
    $display("csv_stream_tokenizer_core: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cst_pkg.sv
rtl/cst_cfg.sv
rtl/cst_step.sv
rtl/cst_ofifo.sv
rtl/csv_stream_tokenizer_core.sv
dv/tb_csv_stream_tokenizer_core.sv
